>>> rtl/scr_pkg.sv
// shared types and constants for the scanline cell renderer
package scr_pkg;

  // video memory geometry
  localparam int VIDEO_DEPTH = 8192;
  localparam int ADDR_W      = 13;

  // raster geometry
  localparam int PICTURE_LINES = 192;
  localparam logic [7:0] ROW_LAST       = 8'd191;
  localparam logic [5:0] CELL_LAST      = 6'd35;
  localparam logic [5:0] CELL_PIC_FIRST = 6'd2;
  localparam logic [5:0] CELL_PIC_LAST  = 6'd33;

  // attribute area starts at 6144, upper three address bits 110
  localparam logic [2:0] ATTR_TOP = 3'b110;

  // command codes
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_t;

  // per-cell information carried from the scan counters to the shader
  typedef struct packed {
    logic [7:0] line;
    logic [5:0] cell_pos;
    logic       border;
    logic [2:0] border_colour;
    logic       flash_on;
    logic       line_end;
    logic       frame_end;
  } cell_info_t;

endpackage

>>> rtl/scanline_cell_renderer_top.sv
// scanline cell renderer top level: video memory, scan counters, shader
//
//  channel   direction  handshake           payload
//  in_       request    in_valid/in_stall   command, mem_address, mem_data, border_colour
//  out_      result     out_valid/out_stall line_number, cell_number, pixel_indices,
//                                           line_end, frame_end
//
// one request per clock while in_stall is low; a render result passes through the registered
// video memory read and then the result register
// write requests give no result and leave the raster position alone
// reset clears the raster, flash and pipeline valid state; video memory is not cleared
// a stalled result holds one render in the read stage, and only then in_stall rises
module scanline_cell_renderer_top #(
  parameter int RASTER_LINES = 224,
  parameter int BORDER_SIZE  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [scr_pkg::ADDR_W-1:0] in_mem_address,
  input  logic [7:0]                 in_mem_data,
  input  logic [2:0]                 in_border_colour,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_line_number,
  output logic [5:0]                 out_cell_number,
  output logic [31:0]                out_pixel_indices,
  output logic                       out_line_end,
  output logic                       out_frame_end
);
  import scr_pkg::*;

  logic               in_take;
  logic               wr_en;
  logic               render;
  logic               out_free;
  logic               s1_vld_r, s1_vld_nxt;
  cell_info_t         s1_info_r;
  cell_info_t         scan_info;
  logic [ADDR_W-1:0]  bmp_addr;
  logic [ADDR_W-1:0]  attr_addr;
  logic [7:0]         bmp_data;
  logic [7:0]         attr_data;

  // request handshake
  assign in_stall = s1_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign wr_en    = in_take && (cmd_t'(in_command) == CMD_WRITE);
  assign render   = in_take && (cmd_t'(in_command) == CMD_RENDER);

  scr_scan_ctrl #(
    .RASTER_LINES (RASTER_LINES),
    .BORDER_SIZE  (BORDER_SIZE)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (render),
    .border_colour (in_border_colour),
    .info          (scan_info),
    .bmp_addr      (bmp_addr),
    .attr_addr     (attr_addr)
  );

  scr_video_mem u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (in_mem_address),
    .wr_data   (in_mem_data),
    .rd_en     (render),
    .bmp_addr  (bmp_addr),
    .attr_addr (attr_addr),
    .bmp_data  (bmp_data),
    .attr_data (attr_data)
  );

  // read stage valid
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (render) begin
      s1_vld_nxt = 1'b1;
    end else if (out_free) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // cell info alongside the memory read
  always_ff @(posedge clk) begin
    if (render) begin
      s1_info_r <= scan_info;
    end
  end

  scr_cell_shade u_shade (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (s1_vld_r),
    .info              (s1_info_r),
    .bmp_data          (bmp_data),
    .attr_data         (attr_data),
    .out_stall         (out_stall),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_line_number   (out_line_number),
    .out_cell_number   (out_cell_number),
    .out_pixel_indices (out_pixel_indices),
    .out_line_end      (out_line_end),
    .out_frame_end     (out_frame_end)
  );

`ifndef SYNTH
  // a held render keeps its cell info
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_free) |=> (s1_vld_r && $stable(s1_info_r)))
    else $error("read stage lost a held render");

  // frame end only on a line end
  a_fend_lend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_line_end)
    else $error("frame end without line end");

  // line end exactly on the last cell
  a_lend_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_end == (out_cell_number == CELL_LAST)))
    else $error("line end on wrong cell");

  // left border cells are a flat non-bright fill
  a_border_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_cell_number < CELL_PIC_FIRST)) |->
      ((out_pixel_indices == {8{out_pixel_indices[3:0]}}) && !out_pixel_indices[3]))
    else $error("border cell not a flat fill");
`endif

endmodule

>>> rtl/scr_video_mem.sv
// video memory: one write port, two registered read ports
module scr_video_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [scr_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [scr_pkg::ADDR_W-1:0] bmp_addr,
  input  logic [scr_pkg::ADDR_W-1:0] attr_addr,
  output logic [7:0]                bmp_data,
  output logic [7:0]                attr_data
);
  import scr_pkg::*;

  logic [7:0] mem_r [VIDEO_DEPTH];
  logic [7:0] bmp_data_r;
  logic [7:0] attr_data_r;

  // byte write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // bitmap and attribute reads, held while no render is accepted
  always_ff @(posedge clk) begin
    if (rd_en) begin
      bmp_data_r  <= mem_r[bmp_addr];
      attr_data_r <= mem_r[attr_addr];
    end
  end

  assign bmp_data  = bmp_data_r;
  assign attr_data = attr_data_r;

endmodule

>>> rtl/scr_scan_ctrl.sv
// raster position counters and video memory address generation
module scr_scan_ctrl #(
  parameter int RASTER_LINES = 224,
  parameter int BORDER_SIZE  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [2:0]                 border_colour,
  output scr_pkg::cell_info_t        info,
  output logic [scr_pkg::ADDR_W-1:0] bmp_addr,
  output logic [scr_pkg::ADDR_W-1:0] attr_addr
);
  import scr_pkg::*;

  localparam int PIC_END = BORDER_SIZE + PICTURE_LINES;

  logic [7:0] line_r, line_nxt;
  logic [5:0] cell_r, cell_nxt;
  logic [3:0] flash_r, flash_nxt;

  logic       pic_line;
  logic       pic_cell;
  logic       lend;
  logic       fend;
  logic [7:0] rel_line;
  logic [7:0] row;
  logic [4:0] col;

  // picture window and screen row (canvas is bottom-up)
  always_comb begin
    pic_line = ({1'b0, line_r} >= 9'(BORDER_SIZE)) && ({1'b0, line_r} < 9'(PIC_END));
    pic_cell = (cell_r >= CELL_PIC_FIRST) && (cell_r <= CELL_PIC_LAST);
    rel_line = line_r - 8'(BORDER_SIZE);
    row      = ROW_LAST - rel_line;
    col      = 5'(cell_r - CELL_PIC_FIRST);
  end

  // interleaved bitmap address and linear attribute address
  assign bmp_addr  = {row[7:6], row[2:0], row[5:3], col};
  assign attr_addr = {ATTR_TOP, row[7:3], col};

  // line and frame ends
  always_comb begin
    lend = (cell_r == CELL_LAST);
    fend = lend && (({1'b0, line_r} + 9'd1) >= 9'(RASTER_LINES));
  end

  // counter advance
  always_comb begin
    line_nxt  = line_r;
    cell_nxt  = cell_r;
    flash_nxt = flash_r;
    if (lend) begin
      cell_nxt = '0;
      if (fend) begin
        line_nxt  = '0;
        flash_nxt = flash_r + 4'd1;
      end else begin
        line_nxt = line_r + 8'd1;
      end
    end else begin
      cell_nxt = cell_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= '0;
      cell_r  <= '0;
      flash_r <= '0;
    end else if (advance) begin
      line_r  <= line_nxt;
      cell_r  <= cell_nxt;
      flash_r <= flash_nxt;
    end
  end

  // cell description for the shader
  always_comb begin
    info.line          = line_r;
    info.cell_pos      = cell_r;
    info.border        = !(pic_line && pic_cell);
    info.border_colour = border_colour;
    info.flash_on      = !flash_r[3];
    info.line_end      = lend;
    info.frame_end     = fend;
  end

endmodule

>>> rtl/scr_cell_shade.sv
// pixel colour selection and result register
module scr_cell_shade (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  scr_pkg::cell_info_t info,
  input  logic [7:0]          bmp_data,
  input  logic [7:0]          attr_data,
  input  logic                out_stall,
  output logic                out_free,
  output logic                out_valid,
  output logic [7:0]          out_line_number,
  output logic [5:0]          out_cell_number,
  output logic [31:0]         out_pixel_indices,
  output logic                out_line_end,
  output logic                out_frame_end
);
  import scr_pkg::*;

  logic        vld_r, vld_nxt;
  logic [7:0]  line_r;
  logic [5:0]  cell_r;
  logic [31:0] pix_r, pix_nxt;
  logic        lend_r;
  logic        fend_r;
  logic [3:0]  ink;
  logic [3:0]  paper;
  logic [3:0]  fg;
  logic [3:0]  bg;
  logic        swap;

  // ink and paper with flash swap
  always_comb begin
    ink   = {attr_data[6], attr_data[2:0]};
    paper = attr_data[6:3];
    swap  = attr_data[7] && info.flash_on;
    fg    = swap ? paper : ink;
    bg    = swap ? ink : paper;
  end

  // eight pixels, leftmost in the top nibble
  always_comb begin
    pix_nxt = '0;
    for (int b = 0; b < 8; b++) begin
      if (info.border) begin
        pix_nxt[4*b +: 4] = {1'b0, info.border_colour};
      end else begin
        pix_nxt[4*b +: 4] = bmp_data[b] ? fg : bg;
      end
    end
  end

  // result register is free when empty or being taken
  assign out_free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (out_free) begin
      vld_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      line_r <= info.line;
      cell_r <= info.cell_pos;
      pix_r  <= pix_nxt;
      lend_r <= info.line_end;
      fend_r <= info.frame_end;
    end
  end

  assign out_valid         = vld_r;
  assign out_line_number   = line_r;
  assign out_cell_number   = cell_r;
  assign out_pixel_indices = pix_r;
  assign out_line_end      = lend_r;
  assign out_frame_end     = fend_r;

endmodule
